/* rtl/gell_pkg.sv */
// Shared types and constants for the Gaussian log-likelihood scoring core.
// Used by gell_cell and gaussian_emission_log_likelihood_core; no dependencies.

package gell_pkg;

	localparam int MAX_STATES   = 16;
	localparam int MAX_FEATURES = 32;

	localparam int STATE_W      = $clog2(MAX_STATES);
	localparam int FEAT_W       = $clog2(MAX_FEATURES);
	localparam int STATE_CNT_W  = $clog2(MAX_STATES + 1);
	localparam int FEAT_CNT_W   = $clog2(MAX_FEATURES + 1);

	localparam int COEF_W       = 32;
	localparam int SAMPLE_W     = 16;
	localparam int ACC_W        = 48;
	localparam int BIAS_W       = 24;
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 24;

	// Register stages in a cell between its input token and the accumulator
	// update, which happens in the cycle after the last stage
	localparam int CELL_LAT     = 5;
	localparam int WAIT_W       = $clog2(MAX_STATES + CELL_LAT);

	localparam int S_TDATA_W    = 128;
	localparam int M_TDATA_W    = 56;

	// Register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_NUM_STATES   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_NUM_FEATURES = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BIAS         = 2'd2;

	// Reset values of the registers
	localparam logic [4:0]        NUM_STATES_RST   = 5'd16;
	localparam logic [5:0]        NUM_FEATURES_RST = 6'd32;
	localparam logic [BIAS_W-1:0] BIAS_RST         = 24'd3854330;

	// Item kinds carried on s_tuser
	localparam logic CMD_LOAD   = 1'b0;
	localparam logic CMD_SAMPLE = 1'b1;

	typedef logic signed [ACC_W-1:0] acc_t;

	typedef struct packed {
		logic signed [COEF_W-1:0] c;
		logic signed [COEF_W-1:0] l;
		logic        [COEF_W-1:0] qd;
	} coef_t;

	// Sample token passed from cell to cell
	typedef struct packed {
		logic                       valid;
		logic signed [SAMPLE_W-1:0] x;
		logic        [FEAT_W-1:0]   feat;
	} wave_t;

	// Accumulator control broadcast to every cell
	typedef struct packed {
		logic shift;
		logic clear;
	} cell_ctl_t;

endpackage

/* rtl/gell_cell.sv */
// One scoring cell: coefficient memory and saturating accumulator for one state.
// Depends on gell_pkg; chained by gaussian_emission_log_likelihood_core.

module gell_cell
	import gell_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  wave_t             wave_in,
	output wave_t             wave_out,
	input  logic              active,
	input  logic              wr_en,
	input  logic [FEAT_W-1:0] wr_addr,
	input  coef_t             wr_coef,
	input  cell_ctl_t         ctl,
	input  acc_t              acc_next,
	output acc_t              acc
);

	localparam int PROD1_W = SAMPLE_W + COEF_W;     // x * quadratic
	localparam int Q_W     = PROD1_W - 8 + 1;       // linear + shifted product
	localparam int PROD2_W = SAMPLE_W + Q_W;        // x * q
	localparam int TERM_W  = ACC_W + 2;
	localparam int SUM_W   = ACC_W + 3;

	localparam acc_t ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
	localparam acc_t ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

	coef_t mem [MAX_FEATURES];

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	coef_t                      coef_s1;
	logic signed [SAMPLE_W-1:0] x_s1, x_s2, x_s3;
	logic signed [PROD1_W-1:0]  prod1_s2;
	logic signed [COEF_W-1:0]   c_s2, c_s3, c_s4;
	logic signed [COEF_W-1:0]   l_s2;
	logic signed [Q_W-1:0]      q_s3;
	logic signed [PROD2_W-1:0]  prod2_s4;
	logic signed [TERM_W-1:0]   term_s5;
	acc_t                       acc_q;

	logic signed [PROD1_W-1:0]  prod1;
	logic signed [Q_W-1:0]      q;
	logic signed [PROD2_W-1:0]  prod2;
	logic signed [TERM_W-1:0]   term;
	logic signed [SUM_W-1:0]    sum;
	acc_t                       sum_sat;

	// Store loaded entries and read the entry of the arriving sample
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_coef;
		end
		coef_s1 <= mem[wave_in.feat];
	end

	// Arithmetic: q = l + x*qd/256, term = c + x*q/256, floors by arithmetic shift
	assign prod1 = PROD1_W'(x_s1) * PROD1_W'($signed({1'b0, coef_s1.qd}));
	assign q     = Q_W'(l_s2) + Q_W'($signed(prod1_s2[PROD1_W-1:8]));
	assign prod2 = PROD2_W'(x_s3) * PROD2_W'(q_s3);
	assign term  = TERM_W'(c_s4) + TERM_W'($signed(prod2_s4[PROD2_W-1:8]));
	assign sum   = SUM_W'(acc_q) + SUM_W'(term_s5);

	// Clip to the 48-bit signed range
	always_comb begin
		if (sum[SUM_W-1:ACC_W-1] == {(SUM_W-ACC_W+1){sum[SUM_W-1]}}) begin
			sum_sat = sum[ACC_W-1:0];
		end else if (sum[SUM_W-1]) begin
			sum_sat = ACC_MIN;
		end else begin
			sum_sat = ACC_MAX;
		end
	end

	// Advance the datapath payload
	always_ff @(posedge clk) begin
		x_s1     <= wave_in.x;
		x_s2     <= x_s1;
		prod1_s2 <= prod1;
		c_s2     <= coef_s1.c;
		l_s2     <= coef_s1.l;
		x_s3     <= x_s2;
		q_s3     <= q;
		c_s3     <= c_s2;
		prod2_s4 <= prod2;
		c_s4     <= c_s3;
		term_s5  <= term;
	end

	// Hand the token on, track valid stages and update the accumulator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wave_out <= '0;
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			v_s3     <= 1'b0;
			v_s4     <= 1'b0;
			v_s5     <= 1'b0;
			acc_q    <= '0;
		end else begin
			wave_out <= wave_in;
			v_s1     <= wave_in.valid & active;
			v_s2     <= v_s1;
			v_s3     <= v_s2;
			v_s4     <= v_s3;
			v_s5     <= v_s4;
			if (ctl.clear) begin
				acc_q <= '0;
			end else if (ctl.shift) begin
				acc_q <= acc_next;
			end else if (v_s5) begin
				acc_q <= sum_sat;
			end
		end
	end

	assign acc = acc_q;

endmodule

/* rtl/gaussian_emission_log_likelihood_core.sv */
// Top level of the diagonal-Gaussian log-likelihood scoring core.
// Depends on gell_pkg and gell_cell (one cell per state, chained).
//
//  Channel  Direction  Signals                          Transfer moves
//  s_axis   in         s_tvalid s_tready s_tdata s_tuser  one load or one sample
//  m_axis   out        m_tvalid m_tready m_tdata m_tlast  one state's result
//  cfg      in         cfg_we cfg_index cfg_data          one register write
//
// A load leaves the core idle. After a sample transfer s_tready stays low while
// the token walks the cell chain one cell per cycle and the last active cell's
// five-stage multiply-accumulate pipeline sets the tail. At frame end the
// accumulators shift out through cell 0, one result per cycle, then a clear
// state zeroes them. Output stalls hold the shift; input is refused while busy.
// Reset is asynchronous; coefficient memories are undefined until loaded.

module gaussian_emission_log_likelihood_core
	import gell_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// state_index[3:0], feature_index[8:4], coef_const[40:9],
	// coef_linear[72:41], coef_quadratic[104:73], sample[120:105], zero pad
	input  logic [S_TDATA_W-1:0]  s_tdata,
	// command[0]
	input  logic                  s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// out_state[3:0], log_likelihood[51:4], zero pad
	output logic [M_TDATA_W-1:0]  m_tdata,
	output logic                  m_tlast,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	typedef struct packed {
		logic [S_TDATA_W-STATE_W-FEAT_W-3*COEF_W-SAMPLE_W-1:0] pad;
		logic signed [SAMPLE_W-1:0] sample;
		logic        [COEF_W-1:0]   quad;
		logic signed [COEF_W-1:0]   lin;
		logic signed [COEF_W-1:0]   cst;
		logic        [FEAT_W-1:0]   feat;
		logic        [STATE_W-1:0]  state;
	} s_data_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WAVE,
		ST_READ,
		ST_CLEAR
	} state_t;

	s_data_t sd;
	state_t  state_q;
	coef_t   load_coef;

	logic [4:0]             num_states_q;
	logic [5:0]             num_features_q;
	logic [BIAS_W-1:0]      bias_q;
	logic [STATE_CNT_W-1:0] ns_eff;
	logic [FEAT_CNT_W-1:0]  nf_eff;

	logic [WAIT_W-1:0]      wait_q;
	logic [FEAT_CNT_W-1:0]  feat_cnt_q;
	logic [STATE_W-1:0]     rd_idx_q;
	wave_t                  wave_q;

	logic                   m_tvalid_q;
	logic                   m_tlast_q;
	logic [STATE_W-1:0]     out_state_q;
	acc_t                   ll_q;

	logic                   in_xfer;
	logic                   slot_free;
	logic                   rd_last;
	cell_ctl_t              ctl;
	logic signed [ACC_W:0]  total;
	logic signed [ACC_W+1:0] neg_total;
	acc_t                   result;

	wave_t wave_c [MAX_STATES+1];
	acc_t  acc_c  [MAX_STATES];
	acc_t  next_c [MAX_STATES];

	assign sd        = s_data_t'(s_tdata);
	assign load_coef = {sd.cst, sd.lin, sd.quad};

	// Clamp the counts into their meaningful ranges
	always_comb begin
		if (num_states_q == '0) begin
			ns_eff = STATE_CNT_W'(1);
		end else if (num_states_q > 5'(MAX_STATES)) begin
			ns_eff = STATE_CNT_W'(MAX_STATES);
		end else begin
			ns_eff = STATE_CNT_W'(num_states_q);
		end
		if (num_features_q == '0) begin
			nf_eff = FEAT_CNT_W'(1);
		end else if (num_features_q > 6'(MAX_FEATURES)) begin
			nf_eff = FEAT_CNT_W'(MAX_FEATURES);
		end else begin
			nf_eff = FEAT_CNT_W'(num_features_q);
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_states_q   <= NUM_STATES_RST;
			num_features_q <= NUM_FEATURES_RST;
			bias_q         <= BIAS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_NUM_STATES:   num_states_q   <= cfg_data[4:0];
				REG_NUM_FEATURES: num_features_q <= cfg_data[5:0];
				REG_BIAS:         bias_q         <= cfg_data[BIAS_W-1:0];
				default:          ;
			endcase
		end
	end

	assign s_tready  = (state_q == ST_IDLE);
	assign in_xfer   = s_tvalid && s_tready;
	assign slot_free = !m_tvalid_q || m_tready;
	assign rd_last   = ({1'b0, rd_idx_q} == ns_eff - STATE_CNT_W'(1));

	assign ctl.shift = (state_q == ST_READ) && slot_free;
	assign ctl.clear = (state_q == ST_CLEAR);

	// Result of the state at the head of the chain: floor(-(bias + sum) / 2)
	assign total     = (ACC_W+1)'($signed({1'b0, bias_q})) + (ACC_W+1)'(acc_c[0]);
	assign neg_total = -((ACC_W+2)'(total));
	assign result    = neg_total[ACC_W:1];

	// Sequencer: sample waves, frame readout and clear
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			wait_q      <= '0;
			feat_cnt_q  <= '0;
			rd_idx_q    <= '0;
			wave_q      <= '0;
			m_tvalid_q  <= 1'b0;
			m_tlast_q   <= 1'b0;
			out_state_q <= '0;
			ll_q        <= '0;
		end else begin
			// Launch a token on a sample transfer; hold a result until it is taken
			wave_q.valid <= in_xfer && (s_tuser == CMD_SAMPLE);
			m_tvalid_q   <= ctl.shift || (m_tvalid_q && !m_tready);
			case (state_q)
				ST_IDLE: begin
					if (in_xfer && s_tuser == CMD_SAMPLE) begin
						wave_q.x     <= sd.sample;
						wave_q.feat  <= feat_cnt_q[FEAT_W-1:0];
						wait_q       <= '0;
						state_q      <= ST_WAVE;
					end
				end
				ST_WAVE: begin
					if (wait_q == WAIT_W'(ns_eff) + WAIT_W'(CELL_LAT - 1)) begin
						if (feat_cnt_q + FEAT_CNT_W'(1) >= nf_eff) begin
							feat_cnt_q <= '0;
							rd_idx_q   <= '0;
							state_q    <= ST_READ;
						end else begin
							feat_cnt_q <= feat_cnt_q + FEAT_CNT_W'(1);
							state_q    <= ST_IDLE;
						end
					end else begin
						wait_q <= wait_q + WAIT_W'(1);
					end
				end
				ST_READ: begin
					if (slot_free) begin
						m_tlast_q   <= rd_last;
						out_state_q <= rd_idx_q;
						ll_q        <= result;
						rd_idx_q    <= rd_idx_q + STATE_W'(1);
						if (rd_last) begin
							state_q <= ST_CLEAR;
						end
					end
				end
				ST_CLEAR: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tlast  = m_tlast_q;
	assign m_tdata  = {{(M_TDATA_W-ACC_W-STATE_W){1'b0}}, ll_q, out_state_q};

	// Chain of cells, one per state
	assign wave_c[0] = wave_q;

	for (genvar j = 0; j < MAX_STATES; j++) begin : g_cell
		logic active;
		logic wr_en;

		assign active = (STATE_CNT_W'(j) < ns_eff);
		assign wr_en  = in_xfer && (s_tuser == CMD_LOAD) && (sd.state == STATE_W'(j));

		if (j == MAX_STATES - 1) begin : g_tail
			assign next_c[j] = '0;
		end else begin : g_link
			assign next_c[j] = acc_c[j+1];
		end

		gell_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.wave_in  (wave_c[j]),
			.wave_out (wave_c[j+1]),
			.active   (active),
			.wr_en    (wr_en),
			.wr_addr  (sd.feat),
			.wr_coef  (load_coef),
			.ctl      (ctl),
			.acc_next (next_c[j]),
			.acc      (acc_c[j])
		);
	end

	// A sample token enters the chain only from idle
	a_wave_from_idle: assert property (@(posedge clk) disable iff (!arst_n)
		wave_q.valid |-> $past(state_q == ST_IDLE))
		else $error("sample token entered while busy");

	// The clear cycle leaves the head accumulator at zero
	a_clear_zeroes: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |=> (acc_c[0] == '0))
		else $error("accumulators not cleared");

	// A stalled result freezes the readout chain
	a_stall_holds_chain: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_READ && m_tvalid_q && !m_tready) |=> $stable(acc_c[0]))
		else $error("readout chain moved under stall");

endmodule
